// ===== sv/spq_pkg.sv =====
// Shared constants and types for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;
  localparam int OCC_W     = 7;
  localparam int STATUS_W  = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_DELETED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [WORD_W-1:0] val;
  } cell_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic                     occupied,
  input  logic                     at_tail,
  input  logic signed [WORD_W-1:0] prev_entry,
  input  logic                     prev_gt,
  input  logic signed [WORD_W-1:0] next_entry,
  output logic signed [WORD_W-1:0] entry,
  output logic                     gt
);

  logic signed [WORD_W-1:0] entry_r;
  logic signed [WORD_W-1:0] entry_nxt;

  assign gt = occupied && (entry_r > cmd.val);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.del) begin
      entry_nxt = next_entry;
    end else if (cmd.ins && (occupied || at_tail)) begin
      if (prev_gt) begin
        entry_nxt = prev_entry;
      end else if (gt || at_tail) begin
        entry_nxt = cmd.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: a chain of entry cells plus count and result registers.
//
// Usage:
//   Raise start with in_kind and in_value for one cycle to issue a transfer.
//   in_kind 0 inserts in_value in ascending order, after any equal entries;
//   in_kind 1 removes the smallest entry. busy is held low: the cell chain
//   compares and shifts every entry in parallel, so an item is taken in every
//   cycle and the sustained rate is one item per cycle.
//   Each item gives one result in the cycle after it is taken, marked by
//   out_strobe for exactly one cycle: out_status, out_removed_value (the
//   removed entry on a delete, else zero) and out_occupancy (entries held
//   after the item). A delete when empty reports ST_EMPTY; an insert when
//   DEPTH entries are held is refused and reports ST_FULL.
//   The receiver cannot stall; results must be taken when strobed.
//   Synchronous reset (rst_n low) empties the queue and drops any pending
//   result; entry cells keep stale data that is never read.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic signed [WORD_W-1:0]   in_value,
  output logic                       out_strobe,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [WORD_W-1:0]   out_removed_value,
  output logic [OCC_W-1:0]           out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      strobe_r;
  status_t                   status_r;
  status_t                   status_nxt;
  logic signed [WORD_W-1:0]  removed_r;
  logic signed [WORD_W-1:0]  removed_nxt;
  logic [OCC_W-1:0]          occ_r;
  logic [CNT_W+OCC_W-1:0]    occ_wide;

  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  cell_cmd_t                 cmd;

  logic signed [WORD_W-1:0]  entry  [DEPTH];
  logic                      gt     [DEPTH];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  assign cmd.ins = accept && !in_kind && !is_full;
  assign cmd.del = accept && in_kind && !is_empty;
  assign cmd.val = in_value;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] prev_e;
      logic                     prev_g;
      logic signed [WORD_W-1:0] next_e;
      if (i == 0) begin : g_first
        assign prev_e = '0;
        assign prev_g = 1'b0;
      end else begin : g_mid
        assign prev_e = entry[i-1];
        assign prev_g = gt[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = entry[i+1];
      end
      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (CNT_W'(i) < count_r),
        .at_tail    (CNT_W'(i) == count_r),
        .prev_entry (prev_e),
        .prev_gt    (prev_g),
        .next_entry (next_e),
        .entry      (entry[i]),
        .gt         (gt[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt   = count_r;
    removed_nxt = '0;
    status_nxt  = ST_INSERTED;
    if (!in_kind) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_INSERTED;
        count_nxt  = count_r + CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt  = ST_DELETED;
        removed_nxt = entry[0];
        count_nxt   = count_r - CNT_W'(1);
      end
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      occ_r     <= occ_wide[OCC_W-1:0];
    end
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_occupancy     = occ_r;

endmodule

// ===== sim/sorted_priority_queue_core_tb.sv =====
// Testbench for the sorted priority queue core: directed and random inserts and deletes.
module sorted_priority_queue_core_tb
  import spq_pkg::*;
();

  localparam int   QDEPTH      = DEPTH_DEF;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef struct {
    status_t                  status;
    logic signed [WORD_W-1:0] removed;
    logic [OCC_W-1:0]         occ;
  } result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_kind = KIND_INSERT;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_strobe;
  logic [STATUS_W-1:0]      out_status;
  logic signed [WORD_W-1:0] out_removed_value;
  logic [OCC_W-1:0]         out_occupancy;

  logic signed [WORD_W-1:0] sorted_vals[$];
  result_t                  pending_results[$];
  int                       mismatches = 0;
  bit                       gaps_on = 1'b1;

  sorted_priority_queue_core #(
    .DEPTH(QDEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_occupancy    (out_occupancy)
  );

  always #2 clk = ~clk;

  function automatic result_t predict_outcome(logic kind, logic signed [WORD_W-1:0] value);
    result_t r;
    int      pos;
    r.removed = '0;
    if (kind == KIND_INSERT) begin
      if (sorted_vals.size() >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = sorted_vals.size();
        while (pos > 0 && sorted_vals[pos-1] > value) pos--;
        sorted_vals.insert(pos, value);
        r.status = ST_INSERTED;
      end
    end else if (sorted_vals.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed = sorted_vals.pop_front();
      r.status  = ST_DELETED;
    end
    r.occ = OCC_W'(sorted_vals.size());
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  // predict on each accepted transfer, then check the strobed result
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n) begin
      if (start && !busy) pending_results.push_back(predict_outcome(in_kind, in_value));
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result status=%0d removed=%0d occ=%0d",
                               out_status, out_removed_value, out_occupancy));
        end else begin
          exp_r = pending_results.pop_front();
          if (out_status !== exp_r.status || out_removed_value !== exp_r.removed ||
              out_occupancy !== exp_r.occ) begin
            flag_error($sformatf(
              "exp status=%0d removed=%0d occ=%0d, got status=%0d removed=%0d occ=%0d",
              exp_r.status, exp_r.removed, exp_r.occ,
              out_status, out_removed_value, out_occupancy));
          end
        end
      end
    end
  end

  task automatic send_item(logic kind, logic signed [WORD_W-1:0] value);
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [WORD_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_and_wait(logic kind, logic signed [WORD_W-1:0] value);
    send_item(kind, value);
    idle_gap();
  endtask

  task automatic test_empty_delete();
    send_and_wait(KIND_DELETE, '0);
    send_and_wait(KIND_DELETE, '1);
  endtask

  task automatic test_extremes();
    send_and_wait(KIND_INSERT, 32'h7FFF_FFFF);
    send_and_wait(KIND_INSERT, 32'h8000_0000);
    send_and_wait(KIND_INSERT, 0);
    send_and_wait(KIND_INSERT, -1);
    send_and_wait(KIND_INSERT, 1);
    send_and_wait(KIND_INSERT, 5);
    send_and_wait(KIND_INSERT, 5);
    send_and_wait(KIND_INSERT, 32'h8000_0000);
    repeat (9) send_and_wait(KIND_DELETE, $urandom);
  endtask

  task automatic test_interleave();
    send_and_wait(KIND_INSERT, 3);
    send_and_wait(KIND_DELETE, 0);
    send_and_wait(KIND_INSERT, -3);
    send_and_wait(KIND_INSERT, 7);
    send_and_wait(KIND_DELETE, 0);
    send_and_wait(KIND_DELETE, 0);
  endtask

  task automatic test_random_mix(int n_items, int insert_pct);
    repeat (n_items) begin
      if ($urandom_range(1, 100) <= insert_pct) send_and_wait(KIND_INSERT, rand_value());
      else send_and_wait(KIND_DELETE, $urandom);
    end
  endtask

  // overfill from any state, then drain past empty
  task automatic test_fill_and_drain();
    repeat (QDEPTH + 3) send_and_wait(KIND_INSERT, rand_value());
    repeat (QDEPTH + 2) send_and_wait(KIND_DELETE, $urandom);
  endtask

  task automatic test_duplicates(int n_items);
    repeat (n_items) begin
      if ($urandom_range(0, 1)) send_and_wait(KIND_INSERT, $signed($urandom_range(0, 8)) - 4);
      else send_and_wait(KIND_DELETE, $urandom);
    end
  endtask

  initial begin
    int guard;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gaps_on = 1'b0;
    test_empty_delete();
    test_extremes();
    gaps_on = 1'b1;
    test_interleave();

    test_random_mix(300, 55);
    gaps_on = 1'b0;
    test_fill_and_drain();
    gaps_on = 1'b1;
    test_fill_and_drain();
    test_duplicates(150);
    test_random_mix(230, 70);

    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
